// ===== sv/hash_join_build_probe_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the hash join engine
// Concurrent checks, clocked on clk and disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef HASH_JOIN_BUILD_PROBE_ASSERT_SVH
`define HASH_JOIN_BUILD_PROBE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define HJBP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hash join check failed");

// antecedent implies consequent in the next cycle
`define HJBP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hash join check failed");

`endif

// ===== sv/hjbp_pkg.sv =====
// ---------------------------------------------------------------------------
// hjbp_pkg
// Shared types and constants of the hash join engine.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package hjbp_pkg;

  localparam int STORE_TUPLES_DEF = 64;
  localparam int BUCKETS_DEF      = 16;

  localparam int PTR_W = 7;
  localparam int BKT_W = 10;
  localparam logic [PTR_W-1:0] EMPTY_MARK = 7'h7F;

  localparam logic [1:0] K_CLEAR = 2'd0;
  localparam logic [1:0] K_BUILD = 2'd1;
  localparam logic [1:0] K_PROBE = 2'd2;
  localparam logic [1:0] K_NONE  = 2'd3;

  typedef struct packed {
    logic [1:0]        kind;
    logic signed [31:0] key;
    logic [30:0]       val;
    logic [BKT_W-1:0]  bucket;
  } item_t;

  typedef struct packed {
    logic              match_valid;
    logic signed [31:0] r_key;
    logic [30:0]       r_val;
    logic signed [31:0] s_key;
    logic [30:0]       s_val;
    logic signed [31:0] sum_so_far;
    logic              status;
    logic              last;
  } res_t;

  typedef struct packed {
    logic [PTR_W-1:0] head;
    logic [PTR_W-1:0] tail;
  } bkt_t;

endpackage

// ===== sv/hjbp_front.sv =====
// ---------------------------------------------------------------------------
// hjbp_front
// Accepts requests, drops unused kinds and reduces the join value to its
// bucket one byte per cycle before handing the request on.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hjbp_front import hjbp_pkg::*; #(
  parameter int BUCKETS = BUCKETS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         kind,
  input  logic signed [31:0] tuple_key,
  input  logic [30:0]        tuple_val,
  output logic               q_push,
  output item_t              q_item,
  input  logic               q_full
);

  typedef enum logic [1:0] {F_IDLE, F_MOD, F_PUSH} fstate_t;

  localparam logic [18:0] BMOD = 19'(BUCKETS);

  fstate_t          state;
  item_t            item;
  logic [BKT_W-1:0] rem;
  logic [BKT_W-1:0] rem_next;
  logic [1:0]       cnt;
  logic [31:0]      v32;
  logic [18:0]      t;

  assign in_stall = (state != F_IDLE);
  assign q_push   = (state == F_PUSH) && !q_full;
  assign q_item   = item;
  assign v32      = {1'b0, item.val};

  always_comb begin
    t = {1'b0, rem, v32[8*(3-cnt) +: 8]};
    for (int k = 7; k >= 0; k--) begin
      if (t >= (BMOD << k)) t = t - (BMOD << k);
    end
    rem_next = t[BKT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      cnt   <= 2'd0;
    end else begin
      case (state)
        F_IDLE: begin
          if (in_valid && kind != K_NONE) begin
            item.kind <= kind;
            item.key  <= tuple_key;
            item.val  <= tuple_val;
            rem       <= '0;
            cnt       <= 2'd0;
            state     <= F_MOD;
          end
        end
        F_MOD: begin
          rem <= rem_next;
          cnt <= cnt + 2'd1;
          if (cnt == 2'd3) begin
            item.bucket <= rem_next;
            state       <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!q_full) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/hjbp_queue.sv =====
// ---------------------------------------------------------------------------
// hjbp_queue
// Two-entry request queue between the front and the back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hjbp_queue import hjbp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  q_valid,
  output item_t q_item
);

  item_t      entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== sv/hjbp_back.sv =====
// ---------------------------------------------------------------------------
// hjbp_back
// Carries out clear, build and probe requests against the bucket table and
// tuple store, and drives the result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hjbp_back import hjbp_pkg::*; #(
  parameter int STORE_TUPLES = STORE_TUPLES_DEF,
  parameter int BUCKETS      = BUCKETS_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  q_valid,
  input  item_t q_item,
  output logic  q_pop,
  output logic  out_valid,
  input  logic  out_stall,
  output res_t  out_res
);

  localparam int SW = (STORE_TUPLES > 1) ? $clog2(STORE_TUPLES) : 1;
  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int CW = $clog2(STORE_TUPLES + 1);
  localparam logic [CW-1:0]    FULL_CNT  = CW'(STORE_TUPLES);
  localparam logic [PTR_W-1:0] STORE_LIM = PTR_W'(STORE_TUPLES);
  localparam logic [BW-1:0]    LAST_BKT  = BW'(BUCKETS - 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_BRD, S_BLNK, S_PWALK, S_PDAT, S_RESP
  } bstate_t;

  bkt_t               bkt_mem  [BUCKETS];
  logic signed [31:0] key_mem  [STORE_TUPLES];
  logic [30:0]        val_mem  [STORE_TUPLES];
  logic [PTR_W-1:0]   next_mem [STORE_TUPLES];

  bstate_t            state;
  logic               init;
  logic [BW-1:0]      sweep;
  logic [CW-1:0]      count;
  logic signed [31:0] sum;
  item_t              cur;
  logic [PTR_W-1:0]   p;
  logic [PTR_W-1:0]   slot_ptr;
  logic [PTR_W-1:0]   link_tail;
  res_t               res;
  res_t               held;
  logic               held_v;

  bkt_t               bdata;
  logic signed [31:0] kdata;
  logic [30:0]        vdata;
  logic [PTR_W-1:0]   ndata;

  logic             bwe, bre, swe, nwe, sre;
  logic [BW-1:0]    bwaddr, braddr;
  bkt_t             bwdata;
  logic [SW-1:0]    swaddr, nwaddr, sraddr;
  logic [PTR_W-1:0] nwdata;
  logic             can_emit, hit, emit;
  logic signed [31:0] sum_add;
  res_t             base_res;
  res_t             full_res;
  res_t             miss_res;
  res_t             fin_res;
  res_t             hit_res;

  assign can_emit = !out_valid || !out_stall;
  assign hit      = (vdata == cur.val);
  assign sum_add  = sum + $signed({1'b0, vdata});
  assign q_pop    = (state == S_IDLE) && q_valid;
  assign emit     = can_emit && ((state == S_RESP) || (state == S_PDAT && hit && held_v));

  always_comb begin
    base_res            = '0;
    base_res.sum_so_far = sum;
    base_res.last       = 1'b1;
    full_res            = base_res;
    full_res.status     = 1'b1;
    miss_res            = base_res;
    miss_res.s_key      = cur.key;
    miss_res.s_val      = cur.val;
    fin_res             = held;
    fin_res.last        = 1'b1;
    hit_res             = '0;
    hit_res.match_valid = 1'b1;
    hit_res.r_key       = kdata;
    hit_res.r_val       = vdata;
    hit_res.s_key       = cur.key;
    hit_res.s_val       = cur.val;
    hit_res.sum_so_far  = sum_add;
  end

  always_comb begin
    bwe    = 1'b0;
    bre    = 1'b0;
    swe    = 1'b0;
    nwe    = 1'b0;
    sre    = 1'b0;
    bwaddr = cur.bucket[BW-1:0];
    braddr = q_item.bucket[BW-1:0];
    bwdata = '{head: EMPTY_MARK, tail: EMPTY_MARK};
    swaddr = count[SW-1:0];
    nwaddr = count[SW-1:0];
    nwdata = EMPTY_MARK;
    sraddr = p[SW-1:0];
    case (state)
      S_CLEAR: begin
        bwe    = 1'b1;
        bwaddr = sweep;
      end
      S_IDLE: begin
        bre = q_valid && (q_item.kind == K_BUILD || q_item.kind == K_PROBE);
      end
      S_BRD: begin
        if (cur.kind == K_BUILD) begin
          swe = 1'b1;
          nwe = 1'b1;
          bwe = 1'b1;
          if (bdata.tail == EMPTY_MARK) begin
            bwdata = '{head: PTR_W'(count), tail: PTR_W'(count)};
          end else begin
            bwdata = '{head: bdata.head, tail: PTR_W'(count)};
          end
        end
      end
      S_BLNK: begin
        nwe    = 1'b1;
        nwaddr = link_tail[SW-1:0];
        nwdata = slot_ptr;
      end
      S_PWALK: begin
        sre = (p < STORE_LIM);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (bwe) bkt_mem[bwaddr] <= bwdata;
    if (bre) bdata <= bkt_mem[braddr];
  end

  always_ff @(posedge clk) begin
    if (swe) begin
      key_mem[swaddr] <= cur.key;
      val_mem[swaddr] <= cur.val;
    end
    if (nwe) next_mem[nwaddr] <= nwdata;
    if (sre) begin
      kdata <= key_mem[sraddr];
      vdata <= val_mem[sraddr];
      ndata <= next_mem[sraddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      init      <= 1'b1;
      sweep     <= '0;
      count     <= '0;
      sum       <= '0;
      held_v    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (emit) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          sweep <= sweep + BW'(1);
          if (sweep == LAST_BKT) begin
            count <= '0;
            if (init) begin
              init  <= 1'b0;
              state <= S_IDLE;
            end else begin
              res   <= base_res;
              state <= S_RESP;
            end
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            cur <= q_item;
            case (q_item.kind)
              K_CLEAR: begin
                sweep <= '0;
                state <= S_CLEAR;
              end
              K_BUILD: begin
                if (count == FULL_CNT) begin
                  res   <= full_res;
                  state <= S_RESP;
                end else begin
                  state <= S_BRD;
                end
              end
              K_PROBE: state <= S_BRD;
              default: state <= S_IDLE;
            endcase
          end
        end
        S_BRD: begin
          if (cur.kind == K_BUILD) begin
            slot_ptr  <= PTR_W'(count);
            link_tail <= bdata.tail;
            count     <= count + CW'(1);
            if (bdata.tail == EMPTY_MARK || bdata.tail >= STORE_LIM) begin
              res   <= base_res;
              state <= S_RESP;
            end else begin
              state <= S_BLNK;
            end
          end else begin
            p      <= bdata.head;
            held_v <= 1'b0;
            state  <= S_PWALK;
          end
        end
        S_BLNK: begin
          res   <= base_res;
          state <= S_RESP;
        end
        S_PWALK: begin
          if (p >= STORE_LIM) begin
            if (held_v) res <= fin_res;
            else res <= miss_res;
            state <= S_RESP;
          end else begin
            state <= S_PDAT;
          end
        end
        S_PDAT: begin
          if (!hit) begin
            p     <= ndata;
            state <= S_PWALK;
          end else if (!held_v || can_emit) begin
            if (held_v) out_res <= held;
            held   <= hit_res;
            held_v <= 1'b1;
            sum    <= sum_add;
            p      <= ndata;
            state  <= S_PWALK;
          end
        end
        S_RESP: begin
          if (can_emit) begin
            out_res <= res;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`include "hash_join_build_probe_assert.svh"

  `HJBP_ASSERT_SAME(a_count_bound, 1'b1, count <= FULL_CNT)
  `HJBP_ASSERT_SAME(a_match_ok, out_valid && out_res.match_valid, !out_res.status)
  `HJBP_ASSERT_NEXT(a_held_set, state == S_PDAT && hit && can_emit, held_v)

endmodule

// ===== sv/hash_join_build_probe.sv =====
// ---------------------------------------------------------------------------
// hash_join_build_probe
// Hash join engine: clear, build and probe requests against a bucketed
// tuple store, with a running sum of matched R values.
// ---------------------------------------------------------------------------
// The front takes a request (accept, byte-wise bucket reduction, hand-off;
// an unused kind is dropped at accept) into a two-entry queue, and takes
// no new one until it has handed that request on. The back takes it from
// the queue in S_IDLE. A clear sweeps the bucket table in S_CLEAR; a build
// goes to S_RESP at once when the store is full, else through S_BRD and,
// when the bucket already holds a tuple, S_BLNK; a probe walks the chain
// with a read in S_PWALK and a compare in S_PDAT per entry, as the tuple
// store has a single read port. A stalled result holds the back. After
// reset the back sweeps the bucket table before it starts on queued requests.
`timescale 1ns / 1ps

module hash_join_build_probe import hjbp_pkg::*; #(
  parameter int STORE_TUPLES = STORE_TUPLES_DEF,
  parameter int BUCKETS      = BUCKETS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         kind,
  input  logic signed [31:0] tuple_key,
  input  logic [30:0]        tuple_val,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               match_valid,
  output logic signed [31:0] r_key,
  output logic [30:0]        r_val,
  output logic signed [31:0] s_key,
  output logic [30:0]        s_val,
  output logic signed [31:0] sum_so_far,
  output logic               status,
  output logic               last
);

  item_t push_item;
  item_t q_item;
  logic  push, full, pop, q_valid;
  res_t  res;

  hjbp_front #(.BUCKETS(BUCKETS)) u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .tuple_key(tuple_key), .tuple_val(tuple_val),
    .q_push(push), .q_item(push_item), .q_full(full)
  );

  hjbp_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_item(push_item), .full(full),
    .pop(pop), .q_valid(q_valid), .q_item(q_item)
  );

  hjbp_back #(.STORE_TUPLES(STORE_TUPLES), .BUCKETS(BUCKETS)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_item(q_item), .q_pop(pop),
    .out_valid(out_valid), .out_stall(out_stall), .out_res(res)
  );

  assign match_valid = res.match_valid;
  assign r_key       = res.r_key;
  assign r_val       = res.r_val;
  assign s_key       = res.s_key;
  assign s_val       = res.s_val;
  assign sum_so_far  = res.sum_so_far;
  assign status      = res.status;
  assign last        = res.last;

endmodule

// ===== bench/hash_join_checker.sv =====
// ---------------------------------------------------------------------------
// Hash join result checker
// Watches the request and result channels of the hash join engine, keeps
// its own bucket table and tuple store, and compares every result field
// against the predicted one in arrival order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hash_join_checker import hjbp_pkg::*; #(
  parameter int STORE_TUPLES = STORE_TUPLES_DEF,
  parameter int BUCKETS      = BUCKETS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         kind,
  input  logic signed [31:0] tuple_key,
  input  logic [30:0]        tuple_val,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               match_valid,
  input  logic signed [31:0] r_key,
  input  logic [30:0]        r_val,
  input  logic signed [31:0] s_key,
  input  logic [30:0]        s_val,
  input  logic signed [31:0] sum_so_far,
  input  logic               status,
  input  logic               last,
  output int                 fail_count,
  output int                 pending
);

  logic [31:0] tup_keys [STORE_TUPLES];
  logic [30:0] tup_vals [STORE_TUPLES];
  logic [6:0]  tup_next [STORE_TUPLES];
  logic [6:0]  head_of [BUCKETS];
  logic [6:0]  tail_of [BUCKETS];
  int          tup_count;
  logic [31:0] run_sum;
  res_t        expected_q[$];

  assign pending = expected_q.size();

  function automatic res_t blank_res();
    res_t r;
    r = '0;
    r.last = 1'b1;
    r.sum_so_far = run_sum;
    return r;
  endfunction

  task automatic join_request(input logic [1:0] k, input logic [31:0] key,
                              input logic [30:0] val);
    int   b;
    int   p;
    int   steps;
    int   hits;
    res_t r;
    b = int'(val % BUCKETS);
    if (k == K_CLEAR) begin
      for (int i = 0; i < BUCKETS; i++) begin
        head_of[i] = EMPTY_MARK;
        tail_of[i] = EMPTY_MARK;
      end
      tup_count = 0;
      expected_q.push_back(blank_res());
    end else if (k == K_BUILD) begin
      r = blank_res();
      if (tup_count >= STORE_TUPLES) begin
        r.status = 1'b1;
      end else begin
        tup_keys[tup_count] = key;
        tup_vals[tup_count] = val;
        tup_next[tup_count] = EMPTY_MARK;
        if (tail_of[b] == EMPTY_MARK) head_of[b] = 7'(tup_count);
        else tup_next[tail_of[b]] = 7'(tup_count);
        tail_of[b] = 7'(tup_count);
        tup_count++;
      end
      expected_q.push_back(r);
    end else if (k == K_PROBE) begin
      p = int'(head_of[b]);
      steps = 0;
      hits = 0;
      while (p < STORE_TUPLES && steps < STORE_TUPLES) begin
        if (tup_vals[p] == val) begin
          run_sum = run_sum + {1'b0, tup_vals[p]};
          r = '0;
          r.match_valid = 1'b1;
          r.r_key = tup_keys[p];
          r.r_val = tup_vals[p];
          r.s_key = key;
          r.s_val = val;
          r.sum_so_far = run_sum;
          expected_q.push_back(r);
          hits++;
        end
        p = int'(tup_next[p]);
        steps++;
      end
      if (hits == 0) begin
        r = blank_res();
        r.s_key = key;
        r.s_val = val;
        expected_q.push_back(r);
      end else begin
        expected_q[$].last = 1'b1;
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    res_t e;
    if (rst) begin
      for (int i = 0; i < BUCKETS; i++) begin
        head_of[i] = EMPTY_MARK;
        tail_of[i] = EMPTY_MARK;
      end
      tup_count = 0;
      run_sum = '0;
      fail_count = 0;
      expected_q.delete();
    end else begin
      if (in_valid && !in_stall) join_request(kind, tuple_key, tuple_val);
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("result with nothing outstanding");
          fail_count++;
        end else begin
          e = expected_q.pop_front();
          check_field("match_valid", 32'(e.match_valid), 32'(match_valid));
          check_field("r_key", e.r_key, r_key);
          check_field("r_val", 32'(e.r_val), 32'(r_val));
          check_field("s_key", e.s_key, s_key);
          check_field("s_val", 32'(e.s_val), 32'(s_val));
          check_field("sum_so_far", e.sum_so_far, sum_so_far);
          check_field("status", 32'(e.status), 32'(status));
          check_field("last", 32'(e.last), 32'(last));
        end
      end
    end
  end

endmodule

// ===== bench/testbench.sv =====
// ---------------------------------------------------------------------------
// Hash join engine testbench
// Drives clear, build, probe and unused-kind requests with random gaps and
// result stalls; a checker beside the engine predicts and checks the results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import hjbp_pkg::*;

  localparam int WATCH_LIMIT = 20000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         kind = K_CLEAR;
  logic signed [31:0] tuple_key = '0;
  logic [30:0]        tuple_val = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               match_valid;
  logic signed [31:0] r_key;
  logic [30:0]        r_val;
  logic signed [31:0] s_key;
  logic [30:0]        s_val;
  logic signed [31:0] sum_so_far;
  logic               status;
  logic               last;
  int                 fail_count;
  int                 pending;
  int                 idle_cycles = 0;
  int                 stall_left = 0;
  logic [30:0]        val_pool [8];

  always #5 clk = ~clk;

  hash_join_build_probe u_dut (.*);
  hash_join_checker u_chk (.*);

  function automatic int gap_len();
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result-side stall
  always @(negedge clk) begin
    int g;
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      g = gap_len();
      out_stall  <= (g > 0);
      stall_left <= (g > 0) ? g - 1 : 0;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCH_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send(input logic [1:0] k, input logic [31:0] key,
                      input logic [30:0] val);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    tuple_key <= key;
    tuple_val <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    logic [1:0]  k;
    logic [30:0] v;
    int          r;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    // directed
    send(K_PROBE, 32'h8000_0000, 31'h7FFF_FFFF);
    send(K_BUILD, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
    send(K_BUILD, 32'h8000_0000, 31'h0);
    send(K_BUILD, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
    send(K_BUILD, 32'h1, 31'h1F);
    send(K_PROBE, 32'h1234_5678, 31'h7FFF_FFFF);
    send(K_PROBE, 32'h0, 31'h0);
    send(K_PROBE, 32'h5, 31'hF);
    send(K_NONE, 32'hA5A5_A5A5, 31'h5555_5555);
    send(K_PROBE, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
    send(K_CLEAR, 32'h0, 31'h0);
    send(K_PROBE, 32'h0, 31'h7FFF_FFFF);
    // fill the store to overflow, then probe across it
    for (int i = 0; i < 66; i++) send(K_BUILD, $urandom, 31'((i % 3) * 16 + 7));
    send(K_PROBE, 32'h3, 31'd7);
    send(K_PROBE, 32'h4, 31'd23);
    drain();
    send(K_CLEAR, 32'h0, 31'h0);
    // random: mostly builds and probes over a small value pool
    for (int i = 0; i < 8; i++) val_pool[i] = 31'({$urandom} >> 1);
    for (int n = 0; n < 250; n++) begin
      r = $urandom_range(0, 99);
      if (r < 4) k = K_CLEAR;
      else if (r < 6) k = K_NONE;
      else if (r < 50) k = K_BUILD;
      else k = K_PROBE;
      v = ($urandom_range(0, 9) < 8) ? val_pool[$urandom_range(0, 7)]
                                      : 31'({$urandom});
      send(k, $urandom, v);
      if (n == 120) drain();
    end
    drain();
    repeat (200) @(negedge clk);
    if (fail_count == 0 && pending == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
